// ===== hw/rtl/srx_pkg.sv =====
package srx_pkg;

    localparam int unsigned R_BLOCKS_DEF   = 1;
    localparam int unsigned LOG2_N_MAX_DEF = 10;
    localparam logic [3:0]  LOG2_N_RESET   = 4'd10;

    typedef logic [15:0][31:0] t_words;

    typedef enum logic [1:0] {
        CORE_NOP,
        CORE_LOAD,
        CORE_XOR,
        CORE_RUN
    } t_core_op;

    typedef struct packed {
        t_core_op    op;
        logic [2:0]  idx;
        logic [63:0] data;
    } t_core_cmd;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FILL,
        ST_MIX_INIT,
        ST_MIX_XOR,
        ST_MIX_RUN,
        ST_MIX_WAIT,
        ST_MIX_STORE,
        ST_COPY,
        ST_IDX,
        ST_RD,
        ST_OUT
    } t_state;

    localparam int unsigned COL_IDX [4][4] = '{
        '{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11}
    };
    localparam int unsigned ROW_IDX [4][4] = '{
        '{0, 1, 2, 3}, '{5, 6, 7, 4}, '{10, 11, 8, 9}, '{15, 12, 13, 14}
    };

    function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // One column round (row low) or one row round (row high) of salsa20.
    function automatic t_words half_round(t_words w, logic row);
        t_words      v;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        v = w;
        for (int q = 0; q < 4; q++) begin
            a = row ? ROW_IDX[q][0] : COL_IDX[q][0];
            b = row ? ROW_IDX[q][1] : COL_IDX[q][1];
            c = row ? ROW_IDX[q][2] : COL_IDX[q][2];
            d = row ? ROW_IDX[q][3] : COL_IDX[q][3];
            v[b] = v[b] ^ rotl32(v[a] + v[d], 7);
            v[c] = v[c] ^ rotl32(v[b] + v[a], 9);
            v[d] = v[d] ^ rotl32(v[c] + v[b], 13);
            v[a] = v[a] ^ rotl32(v[d] + v[c], 18);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/srx_salsa.sv =====
module srx_salsa
    import srx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_cmd   i_cmd,
    output logic        o_busy,
    output logic [63:0] o_word
);

    t_words     r_t;
    t_words     r_w;
    t_words     w_hr;
    logic [2:0] r_cnt;
    logic       r_busy;

    assign w_hr   = half_round(r_w, r_cnt[0]);
    assign o_busy = r_busy;
    assign o_word = {r_t[{i_cmd.idx, 1'b1}], r_t[{i_cmd.idx, 1'b0}]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end else if (i_cmd.op == CORE_RUN) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end
    end

    // Four double rounds, one half round per cycle; the feed-forward add
    // folds into the last one.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt == 3'd7) begin
                for (int i = 0; i < 16; i++) begin
                    r_t[i] <= r_t[i] + w_hr[i];
                end
            end else begin
                r_w <= w_hr;
            end
        end else begin
            case (i_cmd.op)
                CORE_LOAD: begin
                    r_t[{i_cmd.idx, 1'b0}] <= i_cmd.data[31:0];
                    r_t[{i_cmd.idx, 1'b1}] <= i_cmd.data[63:32];
                end
                CORE_XOR: begin
                    r_t[{i_cmd.idx, 1'b0}] <= r_t[{i_cmd.idx, 1'b0}] ^ i_cmd.data[31:0];
                    r_t[{i_cmd.idx, 1'b1}] <= r_t[{i_cmd.idx, 1'b1}] ^ i_cmd.data[63:32];
                end
                CORE_RUN: begin
                    r_w <= r_t;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/srx_scratch.sv =====
module srx_scratch #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/scrypt_romix_salsa8_top.sv =====
// scrypt ROMix core with the salsa20/8 BlockMix. A job starts with 16*R_BLOCKS
// input requests, one 64-bit little-endian word each (two salsa words, low half
// first); the input side stalls from the last word until the whole result has
// been handed to the output register. The cost register log2_n gives N = 2^log2_n,
// with 0 read as 1 and values above LOG2_N_MAX read as LOG2_N_MAX; the value held
// when the last input word arrives is used for the whole job. One shared salsa
// unit does a half round per cycle, and each BlockMix runs 2*R_BLOCKS salsa20/8
// operations back to back. Each fill step copies the block to the scratchpad and
// runs one BlockMix, each mix step reads a scratch block back, folds it in and
// runs one BlockMix. The time is bounded by that salsa unit and the scratchpad,
// which moves one word per cycle. Results leave as 16*R_BLOCKS output requests
// with o_last_word set on the final one; the output register lets the last word
// wait while the next job loads.
module scrypt_romix_salsa8_top
    import srx_pkg::*;
#(
    parameter int unsigned R_BLOCKS   = R_BLOCKS_DEF,
    parameter int unsigned LOG2_N_MAX = LOG2_N_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_word,
    output logic        o_last_word,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);

    localparam int unsigned BW        = 16 * R_BLOCKS;
    localparam int unsigned BWI       = $clog2(BW);
    localparam int unsigned KW        = $clog2(BW + 1);
    localparam int unsigned IW        = $clog2(2 * R_BLOCKS);
    localparam int unsigned LAST_BASE = BW - 8;
    localparam int unsigned DEPTH     = (1 << LOG2_N_MAX) * BW;
    localparam int unsigned AW        = $clog2(DEPTH);

    t_state                r_state;
    t_state                n_state;
    logic [3:0]            r_log2n;
    logic [LOG2_N_MAX-1:0] r_mask;
    logic [LOG2_N_MAX-1:0] n_mask;
    logic [LOG2_N_MAX-1:0] r_j;
    logic [LOG2_N_MAX-1:0] r_m;
    logic [KW-1:0]         r_k;
    logic [IW-1:0]         r_i;
    logic                  r_phase;
    logic                  r_rdv;
    logic [BWI-1:0]        r_rdk;
    logic [63:0]           r_x [BW];
    logic [63:0]           r_y [BW];
    logic                  r_ov;
    logic [63:0]           r_out;
    logic                  r_last;

    logic                  w_in_take;
    logic                  w_out_take;
    logic                  w_out_load;
    logic [4:0]            w_ln;
    logic [IW-1:0]         w_sub;
    logic [BWI-1:0]        w_kidx;
    t_core_cmd             w_cmd;
    logic                  w_busy;
    logic [63:0]           w_word;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [63:0]           w_rdata;

    assign o_stall       = (r_state != ST_LOAD);
    assign w_in_take     = i_valid && !o_stall;
    assign w_out_take    = r_ov && !i_stall;
    assign w_out_load    = (r_state == ST_OUT) && (!r_ov || w_out_take);
    assign o_valid       = r_ov;
    assign o_result_word = r_out;
    assign o_last_word   = r_last;
    assign w_kidx        = r_k[BWI-1:0];

    // Odd sub-blocks land in the upper half of the output block.
    assign w_sub = IW'(r_i >> 1) + (r_i[0] ? IW'(R_BLOCKS) : IW'(0));

    // Clamp the cost to its legal range and turn it into an index mask.
    always_comb begin
        w_ln = {1'b0, r_log2n};
        if (w_ln == 5'd0) begin
            w_ln = 5'd1;
        end else if (32'(w_ln) > LOG2_N_MAX) begin
            w_ln = 5'(LOG2_N_MAX);
        end
        for (int b = 0; b < LOG2_N_MAX; b++) begin
            n_mask[b] = (32'(b) < 32'(w_ln));
        end
    end

    srx_salsa u_salsa (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_word  (w_word)
    );

    assign w_we    = (r_state == ST_FILL);
    assign w_waddr = AW'(32'(r_j) * BW + 32'(r_k));
    assign w_raddr = AW'(32'(r_m) * BW + 32'(r_k));

    srx_scratch #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_x[w_kidx]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Salsa unit commands.
    always_comb begin
        w_cmd.op   = CORE_NOP;
        w_cmd.idx  = r_k[2:0];
        w_cmd.data = '0;
        unique case (r_state)
            ST_MIX_INIT: begin
                w_cmd.op   = CORE_LOAD;
                w_cmd.data = r_x[BWI'(LAST_BASE) + BWI'(r_k[2:0])];
            end
            ST_MIX_XOR: begin
                w_cmd.op   = CORE_XOR;
                w_cmd.data = r_x[BWI'({r_i, r_k[2:0]})];
            end
            ST_MIX_RUN: begin
                w_cmd.op = CORE_RUN;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_take && r_k == KW'(BW - 1)) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_k == KW'(BW - 1)) begin
                    n_state = ST_MIX_INIT;
                end
            end
            ST_MIX_INIT: begin
                if (r_k[2:0] == 3'd7) begin
                    n_state = ST_MIX_XOR;
                end
            end
            ST_MIX_XOR: begin
                if (r_k[2:0] == 3'd7) begin
                    n_state = ST_MIX_RUN;
                end
            end
            ST_MIX_RUN: begin
                n_state = ST_MIX_WAIT;
            end
            ST_MIX_WAIT: begin
                if (!w_busy) begin
                    n_state = ST_MIX_STORE;
                end
            end
            ST_MIX_STORE: begin
                if (r_k[2:0] == 3'd7) begin
                    n_state = (r_i == IW'(2 * R_BLOCKS - 1)) ? ST_COPY : ST_MIX_XOR;
                end
            end
            ST_COPY: begin
                if (r_j == r_mask) begin
                    n_state = r_phase ? ST_OUT : ST_IDX;
                end else begin
                    n_state = r_phase ? ST_IDX : ST_FILL;
                end
            end
            ST_IDX: begin
                n_state = ST_RD;
            end
            ST_RD: begin
                if (r_k == KW'(BW)) begin
                    n_state = ST_MIX_INIT;
                end
            end
            ST_OUT: begin
                if (w_out_load && r_k == KW'(BW - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_log2n <= LOG2_N_RESET;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_phase <= 1'b0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= (r_state == ST_RD) && (r_k != KW'(BW));
            if (i_cfg_we) begin
                r_log2n <= i_cfg_data;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (w_out_take) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_take) begin
                        r_k <= (r_k == KW'(BW - 1)) ? '0 : r_k + KW'(1);
                        r_j     <= '0;
                        r_phase <= 1'b0;
                    end
                end
                ST_FILL, ST_MIX_INIT: begin
                    r_k <= (n_state != r_state) ? '0 : r_k + KW'(1);
                    r_i <= '0;
                end
                // The sub-block index stays put while its words are folded in.
                ST_MIX_XOR: begin
                    r_k <= (n_state != r_state) ? '0 : r_k + KW'(1);
                end
                ST_MIX_STORE: begin
                    if (r_k[2:0] == 3'd7) begin
                        r_k <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_COPY: begin
                    r_k <= '0;
                    if (r_j == r_mask) begin
                        r_j     <= '0;
                        r_phase <= 1'b1;
                    end else begin
                        r_j <= r_j + LOG2_N_MAX'(1);
                    end
                end
                ST_RD: begin
                    r_k <= (r_k == KW'(BW)) ? '0 : r_k + KW'(1);
                    r_i <= '0;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_k <= (r_k == KW'(BW - 1)) ? '0 : r_k + KW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rdk <= w_kidx;
        if (r_state == ST_LOAD && w_in_take) begin
            r_x[w_kidx] <= i_data_word;
            if (r_k == KW'(BW - 1)) begin
                r_mask <= n_mask;
            end
        end
        if (r_state == ST_MIX_STORE) begin
            r_y[BWI'({w_sub, r_k[2:0]})] <= w_word;
        end
        if (r_state == ST_COPY) begin
            for (int k = 0; k < BW; k++) begin
                r_x[k] <= r_y[k];
            end
        end
        if (r_state == ST_IDX) begin
            r_m <= r_x[LAST_BASE][LOG2_N_MAX-1:0] & r_mask;
        end
        if (r_rdv) begin
            r_x[r_rdk] <= r_x[r_rdk] ^ w_rdata;
        end
        if (w_out_load) begin
            r_out  <= r_x[w_kidx];
            r_last <= (r_k == KW'(BW - 1));
        end
    end

`ifndef SYNTHESIS
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX_RUN) |=> w_busy)
        else $error("salsa unit did not start");

    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && r_k == KW'(BW - 1)) |=> (r_state == ST_FILL && o_stall))
        else $error("job did not start after last input word");

    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word && !i_stall) |=> !(o_valid && o_last_word))
        else $error("last word repeated");

    a_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdv |-> ($past(r_state) == ST_RD))
        else $error("scratch read outside read phase");
`endif

endmodule

// ===== test/scrypt_romix_salsa8_top_test.sv =====
`timescale 1ns / 1ps

module scrypt_romix_salsa8_top_test;
    import srx_pkg::*;

    // The predictor below is written for one 128-byte block per job.
    localparam int unsigned JOB_WORDS   = 16;
    localparam int unsigned STALL_LIMIT = 600000;
    localparam int unsigned PAD_WORDS   = (1 << LOG2_N_MAX_DEF) * JOB_WORDS;

    // Quarter-round operand positions: four column steps, then four row steps.
    localparam int QA [8] = '{0, 5, 10, 15, 0, 5, 10, 15};
    localparam int QB [8] = '{4, 9, 14, 3, 1, 6, 11, 12};
    localparam int QC [8] = '{8, 13, 2, 7, 2, 7, 8, 13};
    localparam int QD [8] = '{12, 1, 6, 11, 3, 4, 9, 14};

    typedef logic [7:0][63:0]  sub_block_t;
    typedef logic [15:0][63:0] mix_block_t;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } out_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_data_word;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_word;
    logic        o_last_word;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;

    scrypt_romix_salsa8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_word (o_result_word),
        .o_last_word   (o_last_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state: the cost value as the block holds it, the block being
    // loaded, and the scratchpad that ROMix fills and reads back.
    logic [3:0]  cost_reg;
    mix_block_t  load_buf;
    int unsigned load_pos;
    logic [63:0] scratch_pad [PAD_WORDS];
    out_word_t   pending_words [$];

    int unsigned fail_count;
    int unsigned idle_cycles;
    int unsigned burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot_left(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // salsa20/8 over one 64-byte sub-block held as eight packed 64-bit words.
    function automatic sub_block_t salsa_core(sub_block_t b);
        logic [31:0] x [16];
        logic [31:0] w [16];
        sub_block_t  r;
        for (int i = 0; i < 8; i++) begin
            x[2 * i]     = b[i][31:0];
            x[2 * i + 1] = b[i][63:32];
        end
        w = x;
        for (int dr = 0; dr < 4; dr++) begin
            for (int q = 0; q < 8; q++) begin
                w[QB[q]] ^= rot_left(w[QA[q]] + w[QD[q]], 7);
                w[QC[q]] ^= rot_left(w[QB[q]] + w[QA[q]], 9);
                w[QD[q]] ^= rot_left(w[QC[q]] + w[QB[q]], 13);
                w[QA[q]] ^= rot_left(w[QD[q]] + w[QC[q]], 18);
            end
        end
        for (int i = 0; i < 8; i++) begin
            r[i] = {x[2 * i + 1] + w[2 * i + 1], x[2 * i] + w[2 * i]};
        end
        return r;
    endfunction

    // BlockMix with two sub-blocks: the chain starts from the last sub-block,
    // the even output goes first and the odd one second.
    function automatic mix_block_t block_mix(mix_block_t src);
        sub_block_t t;
        mix_block_t dst;
        for (int j = 0; j < 8; j++) t[j] = src[8 + j] ^ src[j];
        t = salsa_core(t);
        for (int j = 0; j < 8; j++) dst[j] = t[j];
        for (int j = 0; j < 8; j++) t[j] = t[j] ^ src[8 + j];
        t = salsa_core(t);
        for (int j = 0; j < 8; j++) dst[8 + j] = t[j];
        return dst;
    endfunction

    // Full ROMix on the loaded block; pushes the expected result words.
    task automatic predict_romix(input mix_block_t blk);
        int unsigned ln;
        int unsigned n;
        int unsigned m;
        mix_block_t  x;
        out_word_t   ow;
        ln = cost_reg;
        if (ln < 1) ln = 1;
        if (ln > LOG2_N_MAX_DEF) ln = LOG2_N_MAX_DEF;
        n = 1 << ln;
        x = blk;
        for (int j = 0; j < n; j++) begin
            for (int k = 0; k < JOB_WORDS; k++) scratch_pad[j * JOB_WORDS + k] = x[k];
            x = block_mix(x);
        end
        for (int j = 0; j < n; j++) begin
            m = x[8] & (n - 1);
            for (int k = 0; k < JOB_WORDS; k++) x[k] ^= scratch_pad[m * JOB_WORDS + k];
            x = block_mix(x);
        end
        for (int k = 0; k < JOB_WORDS; k++) begin
            ow.word = x[k];
            ow.last = (k == JOB_WORDS - 1);
            pending_words.push_back(ow);
        end
    endtask

    // Sends one request. The sender works in bursts: when a burst runs out it
    // usually drops valid for a random gap. Valid stays high after acceptance so that
    // a following request never lowers and raises it in the same step.
    task automatic send_word(input logic [63:0] w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_word <= w;
        do @(posedge i_clk); while (o_stall);
        load_buf[load_pos] = w;
        load_pos++;
        if (load_pos == JOB_WORDS) begin
            load_pos = 0;
            predict_romix(load_buf);
        end
    endtask

    // Holds the sender off until every expected result has been seen.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cost(input logic [3:0] v);
        i_valid    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        cost_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_job();
        for (int k = 0; k < JOB_WORDS; k++) send_word({$urandom, $urandom});
    endtask

    // Reset cost (the largest N) with field extremes in the block.
    task automatic test_reset_cost();
        for (int k = 0; k < JOB_WORDS; k++) begin
            case (k % 4)
                0: send_word(64'd0);
                1: send_word({64{1'b1}});
                2: send_word(64'h5555_5555_AAAA_AAAA);
                default: send_word(64'h0000_0001_8000_0000);
            endcase
        end
        wait_drained();
    endtask

    // A cost of zero runs as one, and one is the smallest legal cost.
    task automatic test_cost_low();
        write_cost(4'd0);
        send_random_job();
        wait_drained();
        write_cost(4'd1);
        send_random_job();
        wait_drained();
    endtask

    // Costs above the maximum are clamped to it.
    task automatic test_cost_high();
        write_cost(4'd15);
        send_random_job();
        wait_drained();
    endtask

    // A cost written part way through loading is the one that the job uses.
    task automatic test_cost_during_load();
        write_cost(4'd2);
        for (int k = 0; k < JOB_WORDS / 2; k++) send_word({$urandom, $urandom});
        write_cost(4'd3);
        for (int k = 0; k < JOB_WORDS / 2; k++) send_word({$urandom, $urandom});
        wait_drained();
    endtask

    // Random jobs at small costs, some back to back so the next block loads
    // while the previous result is still leaving.
    task automatic test_random_jobs();
        for (int j = 0; j < 2; j++) begin
            if ($urandom_range(0, 1) != 0) begin
                wait_drained();
                write_cost(4'($urandom_range(1, 4)));
            end
            send_random_job();
        end
        wait_drained();
    endtask

    // The output side stalls on a pattern of its own: each stretch picks a
    // stall density, from none at all up to mostly stalled.
    initial begin
        int unsigned density;
        int unsigned stretch;
        i_stall = 1'b0;
        forever begin
            density = $urandom_range(0, 3);
            stretch = $urandom_range(16, 200);
            repeat (stretch) begin
                @(posedge i_clk);
                i_stall <= (density != 0) && ($urandom_range(0, 7) < density * 2);
            end
        end
    end

    // Result checker: every accepted result is compared with the oldest
    // expected word.
    always @(posedge i_clk) begin
        out_word_t exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, o_result_word,
                         o_last_word);
                fail_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_result_word !== exp_w.word) begin
                    $display("%0t: result_word expected %h actual %h", $time, exp_w.word,
                             o_result_word);
                    fail_count++;
                end
                if (o_last_word !== exp_w.last) begin
                    $display("%0t: last_word expected %b actual %b", $time, exp_w.last,
                             o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a full-cost job is long, but nothing near this limit.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_word = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        cost_reg    = LOG2_N_RESET;
        load_pos    = 0;
        fail_count  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_cost();
        test_cost_low();
        test_cost_high();
        test_cost_during_load();
        test_random_jobs();

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
